### rtl/core/hlcfp_pkg.sv
// Shared types, constants and the byte-wide CRC for the frame parser.
package hlcfp_pkg;

  // Register map
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam logic [CfgIdxW-1:0] RegHeaderBytes  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderLength = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxPayload   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCrcEnable    = 2'd3;

  // Reset values
  localparam logic [63:0] HeaderBytesRst  = 64'd21930;
  localparam logic [3:0]  HeaderLengthRst = 4'd2;
  localparam logic [15:0] MaxPayloadRst   = 16'd256;
  localparam logic        CrcEnableRst    = 1'b1;

  // Header length limits
  localparam logic [3:0] MinHeaderBytes = 4'd2;
  localparam logic [3:0] MaxHeaderBytes = 4'd8;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhHeader  = 3'd1,
    PhLenHi   = 3'd2,
    PhLenLo   = 3'd3,
    PhPayload = 3'd4,
    PhCrcHi   = 3'd5,
    PhCrcLo   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    StNone = 2'd0,
    StOk   = 2'd1,
    StLong = 2'd2,
    StCrc  = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] header_bytes;
    logic [3:0]  hdr_count;
    logic [15:0] max_payload;
    logic        crc_check_enable;
  } cfg_t;

  typedef struct packed {
    logic [15:0] length_field;
    status_e     frame_status;
    logic [15:0] payload_index;
    logic        payload_valid;
    logic [7:0]  payload_byte;
  } res_t;

  // One byte through the MSB-first CRC, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/hlcfp_cfg_regs.sv
// Configuration register bank for the frame parser.
module hlcfp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [hlcfp_pkg::CfgIdxW-1:0]  index_i,
  input  logic [hlcfp_pkg::CfgDataW-1:0] wdata_i,
  output hlcfp_pkg::cfg_t               cfg_o
);
  import hlcfp_pkg::*;

  cfg_t cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_bytes     <= HeaderBytesRst;
      cfg_q.hdr_count        <= HeaderLengthRst;
      cfg_q.max_payload      <= MaxPayloadRst;
      cfg_q.crc_check_enable <= CrcEnableRst;
    end else if (we_i) begin
      unique case (index_i)
        RegHeaderBytes:  cfg_q.header_bytes     <= wdata_i;
        RegHeaderLength: cfg_q.hdr_count        <= wdata_i[3:0];
        RegMaxPayload:   cfg_q.max_payload      <= wdata_i[15:0];
        RegCrcEnable:    cfg_q.crc_check_enable <= wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/hlcfp_in_stage.sv
// Input register: holds one received byte until the parser takes it.
module hlcfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // Free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### rtl/core/hlcfp_parser.sv
// Frame parser state machine, CRC accumulator and result formation.
module hlcfp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hlcfp_pkg::cfg_t     cfg_i,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output logic                produce_o,
  output hlcfp_pkg::res_t     res_o,
  output hlcfp_pkg::phase_e   phase_o
);
  import hlcfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic [3:0]  hdr_len;
  logic [7:0]  hdr_pos_byte;
  logic [7:0]  hdr_first_byte;
  logic        match_pos, match_first;
  logic [3:0]  pos_inc;
  logic        hdr_done;
  logic [15:0] crc_base, crc_new;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  logic        last_byte;
  logic        crc_match;
  status_e     status;

  // Clamp header length to the supported range
  always_comb begin
    if (cfg_i.hdr_count < MinHeaderBytes) begin
      hdr_len = MinHeaderBytes;
    end else if (cfg_i.hdr_count > MaxHeaderBytes) begin
      hdr_len = MaxHeaderBytes;
    end else begin
      hdr_len = cfg_i.hdr_count;
    end
  end

  // Header compare
  assign hdr_pos_byte   = cfg_i.header_bytes[{pos_q, 3'b000} +: 8];
  assign hdr_first_byte = cfg_i.header_bytes[7:0];
  assign match_pos      = (byte_i == hdr_pos_byte);
  assign match_first    = (byte_i == hdr_first_byte);
  assign pos_inc        = {1'b0, pos_q} + 4'd1;
  assign hdr_done       = (pos_inc >= hdr_len);

  // CRC restarts on a fresh header start
  assign crc_base = ((phase_q == PhIdle) || ((phase_q == PhHeader) && !match_pos))
                    ? CrcInit : crc_q;
  assign crc_new  = crc_byte(crc_base, byte_i);

  // Length, payload count and CRC compare
  assign len_full  = {len_q[15:8], byte_i};
  assign cnt_inc   = cnt_q + 16'd1;
  assign last_byte = (cnt_inc >= len_q) || (cnt_inc == 16'd0);
  assign crc_match = ({crc_hi_q, byte_i} == crc_q);

  // Frame status for this byte
  always_comb begin
    status = StNone;
    unique case (phase_q)
      PhLenLo: begin
        if (len_full > cfg_i.max_payload) begin
          status = StLong;
        end else if ((len_full == 16'd0) && !cfg_i.crc_check_enable) begin
          status = StOk;
        end
      end
      PhPayload: begin
        if (last_byte && !cfg_i.crc_check_enable) begin
          status = StOk;
        end
      end
      PhCrcHi: begin
        if (!cfg_i.crc_check_enable) begin
          status = StOk;
        end
      end
      PhCrcLo: begin
        if (!cfg_i.crc_check_enable || crc_match) begin
          status = StOk;
        end else begin
          status = StCrc;
        end
      end
      default: status = StNone;
    endcase
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhIdle: begin
        if (match_first) begin
          phase_d = PhHeader;
        end
      end
      PhHeader: begin
        if (match_pos) begin
          if (hdr_done) begin
            phase_d = PhLenHi;
          end
        end else if (!match_first) begin
          phase_d = PhIdle;
        end
      end
      PhLenHi: phase_d = PhLenLo;
      PhLenLo: begin
        if (status != StNone) begin
          phase_d = PhIdle;
        end else if (len_full == 16'd0) begin
          phase_d = PhCrcHi;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        if (last_byte) begin
          phase_d = cfg_i.crc_check_enable ? PhCrcHi : PhIdle;
        end
      end
      PhCrcHi: phase_d = cfg_i.crc_check_enable ? PhCrcLo : PhIdle;
      PhCrcLo: phase_d = PhIdle;
      default: phase_d = PhIdle;
    endcase
  end

  // Datapath register updates
  always_comb begin
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    len_d    = len_q;
    crc_hi_d = crc_hi_q;
    unique case (phase_q)
      PhIdle: begin
        if (match_first) begin
          crc_d = crc_new;
          pos_d = 3'd1;
        end
      end
      PhHeader: begin
        if (match_pos) begin
          crc_d = crc_new;
          pos_d = hdr_done ? 3'd0 : pos_inc[2:0];
        end else if (match_first) begin
          crc_d = crc_new;
          pos_d = 3'd1;
        end else begin
          pos_d = 3'd0;
        end
      end
      PhLenHi: begin
        crc_d = crc_new;
        len_d = {byte_i, 8'h00};
      end
      PhLenLo: begin
        crc_d = crc_new;
        len_d = len_full;
        cnt_d = 16'd0;
      end
      PhPayload: begin
        crc_d = crc_new;
        cnt_d = last_byte ? 16'd0 : cnt_inc;
      end
      PhCrcHi: crc_hi_d = byte_i;
      PhCrcLo: ;
      default: begin
        pos_d = 3'd0;
        cnt_d = 16'd0;
      end
    endcase
    // Every status ends the frame
    if (status != StNone) begin
      pos_d = 3'd0;
      cnt_d = 16'd0;
    end
  end

  // Result formation
  always_comb begin
    res_o.payload_valid = (phase_q == PhPayload);
    res_o.payload_byte  = res_o.payload_valid ? byte_i : 8'h00;
    res_o.payload_index = res_o.payload_valid ? cnt_q : 16'd0;
    res_o.frame_status  = status;
    if (status == StNone) begin
      res_o.length_field = 16'd0;
    end else if (phase_q == PhLenLo) begin
      res_o.length_field = len_full;
    end else begin
      res_o.length_field = len_q;
    end
  end

  assign produce_o = res_o.payload_valid || (status != StNone);
  assign phase_o   = phase_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pos_q   <= 3'd0;
      cnt_q   <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  // Frame data
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      crc_q    <= crc_d;
      len_q    <= len_d;
      crc_hi_q <= crc_hi_d;
    end
  end

endmodule

### rtl/core/hlcfp_out_stage.sv
// Result register feeding the master-side stream.
module hlcfp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hlcfp_pkg::res_t  res_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output hlcfp_pkg::res_t  res_o
);
  import hlcfp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Slot is free when empty or its transaction completes now
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### rtl/core/header_length_crc_frame_parser_core.sv
// Path: input register, parser step and byte-wide CRC, then result register.
// Throughput: one byte per cycle while the result register is free or the byte yields no result.
// A byte that yields no result is consumed even while the result register is held by the sink.
// Reset: rst_ni, asynchronous active low, returns the parser to idle, empties both registers
// and loads the configuration reset values; s_axis_tready is high once reset is released.
module header_length_crc_frame_parser_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [hlcfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hlcfp_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Received bytes
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hlcfp_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] rx_byte
  // Results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] payload_byte, [23:8] payload_index, [25:24] frame_status,
  // [41:26] length_field, [47:42] zero
  output logic [hlcfp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tuser    // payload_valid
);
  import hlcfp_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       step;
  logic       produce;
  logic       out_free;
  res_t       res;
  res_t       res_out;
  phase_e     phase;

  hlcfp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  hlcfp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .take_i  (step),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  // Advance unless a result would land on an occupied result register
  assign step = in_valid && (out_free || !produce);

  hlcfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .byte_i    (in_byte),
    .produce_o (produce),
    .res_o     (res),
    .phase_o   (phase)
  );

  hlcfp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && produce),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  // Output packing
  assign m_axis_tdata = {6'd0, res_out.length_field, res_out.frame_status,
                         res_out.payload_index, res_out.payload_byte};
  assign m_axis_tuser = res_out.payload_valid;

  // A result without payload must carry a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (res_out.frame_status != StNone))
    else $error("result with neither payload nor status");

  // A status ends the frame: parser is idle afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (res.frame_status != StNone)) |=> (phase == PhIdle))
    else $error("parser not idle after frame status");

  // Input back-pressure only when both registers are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && produce))
    else $error("input stalled without a full result register");

  // A loaded payload result is presented as a valid output with tuser set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && produce && res.payload_valid) |=> (m_axis_tvalid && m_axis_tuser))
    else $error("payload result lost on load");

endmodule
